[design/dde_pkg.sv]
// ----------------------------------------------------------------------------
// Directory entry deframer package
// Shared constants and types for the directory entry deframer.
// ----------------------------------------------------------------------------
package dde_pkg;

    localparam int HDR_BYTES     = 8;
    localparam int LG_W          = 5;
    localparam int LG_MIN        = 10;
    localparam int LG_MAX        = 16;
    localparam int LIMIT_POW_W   = LG_MAX + 1;
    localparam int REC_W         = 16;

    localparam logic [LG_W-1:0] LG_RESET = LG_W'(LG_MIN);

    typedef struct packed {
        logic [63:0]      header;
        logic [REC_W-1:0] record_offset;
        logic [REC_W-1:0] record_length;
        logic             stopped;
    } dde_state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] entry_inode;
        logic [7:0]  entry_type;
        logic [7:0]  name_length;
        logic [7:0]  name_byte;
        logic [7:0]  name_index;
        logic        last_of_name;
        logic        name_clipped;
    } dde_result_t;

endpackage

[design/dde_step.sv]
// ----------------------------------------------------------------------------
// Directory entry deframer step logic
// Next-state and result logic for one block byte.
// ----------------------------------------------------------------------------
module dde_step #(
    parameter int MAX_BLOCK_BYTES = 65536
) (
    input  dde_pkg::dde_state_t                         state,
    input  logic [$clog2(MAX_BLOCK_BYTES+1)-1:0]        block_offset,
    input  logic [7:0]                                  data_byte,
    input  logic                                        block_start,
    input  logic [dde_pkg::LG_W-1:0]                    block_size_log2,
    output dde_pkg::dde_state_t                         state_next,
    output logic [$clog2(MAX_BLOCK_BYTES+1)-1:0]        block_offset_next,
    output dde_pkg::dde_result_t                        result
);
    import dde_pkg::*;

    localparam int OFS_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CMP_W = (OFS_W > REC_W ? OFS_W : REC_W) + 2;
    localparam logic [LIMIT_POW_W-1:0] MAX_B = LIMIT_POW_W'(MAX_BLOCK_BYTES);

    dde_state_t           cur;
    logic [OFS_W-1:0]     pos;
    logic [LG_W-1:0]      lg;
    logic [LIMIT_POW_W-1:0] pow_bytes;
    logic [OFS_W-1:0]     limit;
    logic [CMP_W-1:0]     left;
    logic [REC_W-1:0]     rl;
    logic [63:0]          hdr;
    logic [REC_W-1:0]     idx;
    logic [REC_W-1:0]     room;
    logic [REC_W-1:0]     shown;
    logic [REC_W-1:0]     nlen16;
    logic [REC_W:0]       ro_inc;
    logic [2:0]           lane;

    always_comb
    begin
        cur = state;
        pos = block_offset;
        if (block_start)
        begin
            cur.record_offset = '0;
            cur.record_length = '0;
            cur.stopped       = 1'b0;
            pos               = '0;
        end

        lg = block_size_log2;
        if (lg < LG_W'(LG_MIN))
        begin
            lg = LG_W'(LG_MIN);
        end
        if (lg > LG_W'(LG_MAX))
        begin
            lg = LG_W'(LG_MAX);
        end
        pow_bytes = LIMIT_POW_W'(1) << lg;
        if (pow_bytes > MAX_B)
        begin
            pow_bytes = MAX_B;
        end
        limit = OFS_W'(pow_bytes);

        left   = CMP_W'(limit) - CMP_W'(pos);
        lane   = cur.record_offset[2:0];
        hdr    = cur.header;
        hdr[lane*8 +: 8] = data_byte;
        rl     = hdr[47:32];
        idx    = cur.record_offset - REC_W'(HDR_BYTES);
        room   = cur.record_length - REC_W'(HDR_BYTES);
        nlen16 = REC_W'(cur.header[55:48]);
        shown  = (nlen16 < room) ? nlen16 : room;
        ro_inc = {1'b0, cur.record_offset} + 17'd1;

        state_next        = cur;
        block_offset_next = pos;
        result            = '0;
        result.entry_inode  = cur.header[31:0];
        result.name_length  = cur.header[55:48];
        result.entry_type   = cur.header[63:56];
        result.name_byte    = data_byte;
        result.name_index   = idx[7:0];
        result.last_of_name = ((idx + REC_W'(1)) == shown);
        result.name_clipped = (nlen16 > room);

        if (pos < limit)
        begin
            block_offset_next = pos + OFS_W'(1);
            if (!cur.stopped)
            begin
                if (cur.record_offset < REC_W'(HDR_BYTES))
                begin
                    if (cur.record_offset == '0 && left < CMP_W'(HDR_BYTES))
                    begin
                        state_next.stopped = 1'b1;
                    end
                    else
                    begin
                        state_next.header = hdr;
                        if (cur.record_offset == REC_W'(HDR_BYTES - 1))
                        begin
                            state_next.record_length = rl;
                            if (rl < REC_W'(HDR_BYTES)
                                || CMP_W'(rl) > left + CMP_W'(HDR_BYTES - 1))
                            begin
                                state_next.stopped       = 1'b1;
                                state_next.record_offset = '0;
                            end
                            else if (rl == REC_W'(HDR_BYTES))
                            begin
                                state_next.record_offset = '0;
                            end
                            else
                            begin
                                state_next.record_offset = REC_W'(HDR_BYTES);
                            end
                        end
                        else
                        begin
                            state_next.record_offset = cur.record_offset + REC_W'(1);
                        end
                    end
                end
                else
                begin
                    result.valid = (cur.header[31:0] != '0) && (nlen16 != '0)
                                   && (idx < nlen16) && (idx < room);
                    if (ro_inc >= {1'b0, cur.record_length})
                    begin
                        state_next.record_offset = '0;
                    end
                    else
                    begin
                        state_next.record_offset = ro_inc[REC_W-1:0];
                    end
                end
            end
        end
    end

endmodule

[design/directory_entry_deframer.sv]
// ----------------------------------------------------------------------------
// Directory entry deframer
// Parses linear directory blocks one byte per item and emits name bytes.
// ----------------------------------------------------------------------------
// The block takes one directory block byte per cycle and answers each item
// with at most one name character, in the next cycle, from a single output
// register; throughput is one item per cycle whenever the output side keeps
// taking results, since in_ready stays high while the output register is
// empty or being emptied in the same cycle.
module directory_entry_deframer #(
    parameter int MAX_BLOCK_BYTES = 65536
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [dde_pkg::LG_W-1:0]  block_size_log2,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                data_byte,
    input  logic                      block_start,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               entry_inode,
    output logic [7:0]                entry_type,
    output logic [7:0]                name_length,
    output logic [7:0]                name_byte,
    output logic [7:0]                name_index,
    output logic                      last_of_name,
    output logic                      name_clipped
);
    import dde_pkg::*;

    localparam int OFS_W = $clog2(MAX_BLOCK_BYTES + 1);

    logic [LG_W-1:0]  lg_reg;
    logic [OFS_W-1:0] block_offset_reg;
    logic [OFS_W-1:0] block_offset_next;
    dde_state_t       state_reg;
    dde_state_t       state_next;
    dde_result_t      result_next;
    dde_result_t      result_reg;
    logic             in_fire;

    assign in_ready = !result_reg.valid || out_ready;
    assign in_fire  = in_valid && in_ready;

    dde_step #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_step (
        .state             (state_reg),
        .block_offset      (block_offset_reg),
        .data_byte         (data_byte),
        .block_start       (block_start),
        .block_size_log2   (lg_reg),
        .state_next        (state_next),
        .block_offset_next (block_offset_next),
        .result            (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_reg           <= LG_RESET;
            block_offset_reg <= '0;
            state_reg        <= '0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lg_reg <= block_size_log2;
            end
            if (in_fire)
            begin
                block_offset_reg <= block_offset_next;
                state_reg        <= state_next;
                result_reg       <= result_next;
            end
            else if (out_ready)
            begin
                result_reg.valid <= 1'b0;
            end
        end
    end

    assign out_valid    = result_reg.valid;
    assign entry_inode  = result_reg.entry_inode;
    assign entry_type   = result_reg.entry_type;
    assign name_length  = result_reg.name_length;
    assign name_byte    = result_reg.name_byte;
    assign name_index   = result_reg.name_index;
    assign last_of_name = result_reg.last_of_name;
    assign name_clipped = result_reg.name_clipped;

endmodule

[design/dde_checker.sv]
// ----------------------------------------------------------------------------
// Directory entry deframer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dde_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] entry_inode,
    input logic [7:0]  name_length,
    input logic [7:0]  name_byte,
    input logic [7:0]  name_index,
    input logic        last_of_name,
    input logic        name_clipped
);

    logic [8:0] index_plus_one;

    assign index_plus_one = {1'b0, name_index} + 9'd1;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(name_byte)
                                    && $stable(name_index))
        else $error("Stalled result item changed.");

    a_live_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_inode != 32'd0 && name_index < name_length)
        else $error("Result item from a dead entry or past the name.");

    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_name && !name_clipped
            |-> index_plus_one == {1'b0, name_length})
        else $error("Unclipped name ended early.");

    a_clipped_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && name_clipped |-> index_plus_one < {1'b0, name_length})
        else $error("Clipped name reached its declared length.");

endmodule

bind directory_entry_deframer dde_checker u_dde_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .entry_inode  (entry_inode),
    .name_length  (name_length),
    .name_byte    (name_byte),
    .name_index   (name_index),
    .last_of_name (last_of_name),
    .name_clipped (name_clipped)
);
